[rtl/cfs_pkg.sv]
`default_nettype none
package cfs_pkg;

  localparam int unsigned GridRows = 64;
  localparam int unsigned GridCols = 64;

  localparam int unsigned DataW  = 24;
  localparam int unsigned DensW  = 16;
  localparam int unsigned GainW  = 24;
  localparam int unsigned StepW  = 16;
  localparam int unsigned CmdW   = 2;
  localparam int unsigned CoordW = 6;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CmdW-1:0] CMD_WRITE = 2'd0;
  localparam logic [CmdW-1:0] CMD_RUN   = 2'd1;
  localparam logic [CmdW-1:0] CMD_READ  = 2'd2;

  localparam logic [1:0] KIND_WRITE_ACK = 2'd0;
  localparam logic [1:0] KIND_RUN_DONE  = 2'd1;
  localparam logic [1:0] KIND_READ_DATA = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_LAP_GAIN   = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_POT_GAIN   = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_STEP_COUNT = 2'd2;

  localparam logic signed [DataW-1:0] VAL_MAX = 24'sh7FFFFF;
  localparam logic signed [DataW-1:0] VAL_MIN = 24'sh800000;

endpackage
`default_nettype wire

[rtl/cfs_ram.sv]
`default_nettype none
module cfs_ram #(
  parameter int unsigned Width = 24,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/complex_field_stencil_euler_step_core.sv]
`default_nettype none
// channel  direction  handshake               payload
// in       slave      in_valid_i / in_stall_o   cmd, row, col, in_re, in_im, density
// out      master     out_valid_o / out_stall_i out_re, out_im, kind
// cfg      slave      cfg_we_i                  cfg_idx_i, cfg_data_i
// a write or read result is registered once the done state finds the output register free
// a run visits each grid point in turn for every step (centre and four neighbour reads through
// the single read port of each field ram, then gain products and write-back), and its result
// follows once the last step is written back
// the field is kept in two banks per component; a step reads one and writes the other
// reset sets control and the config registers only, the rams are undefined until written
// a stalled result still lets one more command in; that one then waits in the done state
// and the input stays stalled until the output register frees
module complex_field_stencil_euler_step_core #(
  parameter int unsigned GRID_ROWS = cfs_pkg::GridRows,
  parameter int unsigned GRID_COLS = cfs_pkg::GridCols
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [cfs_pkg::CfgIdxW-1:0]         cfg_idx_i,
  input  wire logic [cfs_pkg::GainW-1:0]           cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [cfs_pkg::CmdW-1:0]            cmd_i,
  input  wire logic [cfs_pkg::CoordW-1:0]          row_i,
  input  wire logic [cfs_pkg::CoordW-1:0]          col_i,
  input  wire logic signed [cfs_pkg::DataW-1:0]    in_re_i,
  input  wire logic signed [cfs_pkg::DataW-1:0]    in_im_i,
  input  wire logic [cfs_pkg::DensW-1:0]           density_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic signed [cfs_pkg::DataW-1:0]         out_re_o,
  output logic signed [cfs_pkg::DataW-1:0]         out_im_o,
  output logic [1:0]                               kind_o
);

  localparam int unsigned NPts = GRID_ROWS * GRID_COLS;
  localparam int unsigned AW   = $clog2(NPts);
  localparam int unsigned RW   = $clog2(GRID_ROWS);
  localparam int unsigned CW   = $clog2(GRID_COLS);
  localparam int unsigned FieldDepth = 2 * (1 << AW);
  localparam int unsigned DW   = cfs_pkg::DataW;
  localparam int unsigned LapW = DW + 4;
  localparam int unsigned SumW = DW + 2;
  localparam int unsigned PW   = cfs_pkg::GainW + 1 + LapW;
  localparam int unsigned TW   = PW + 1;
  localparam int unsigned NW   = TW - 16 + 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_RUN  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [3:0] PH_LAST = 4'd8;

  logic [1:0] state_q, state_d;
  logic [cfs_pkg::GainW-1:0] lap_gain_q, pot_gain_q;
  logic [cfs_pkg::StepW-1:0] step_count_q, steps_q, steps_d;
  logic [3:0] ph_q, ph_d;
  logic [RW-1:0] r_q, r_d;
  logic [CW-1:0] c_q, c_d;
  logic bank_q, bank_d;
  logic [1:0] res_kind_q, res_kind_d;
  logic res_zero_q, res_zero_d;

  logic out_valid_q;
  logic signed [DW-1:0] out_re_q, out_im_q;
  logic [1:0] out_kind_q;

  logic signed [DW-1:0] c_re_q, c_im_q;
  logic [cfs_pkg::DensW-1:0] dens_q;
  logic signed [SumW-1:0] sum_re_q, sum_im_q;
  logic [cfs_pkg::GainW+cfs_pkg::DensW-1:0] vprod_q;
  logic signed [LapW-1:0] lap_re_q, lap_im_q;
  logic [cfs_pkg::GainW-1:0] v_q;
  logic signed [PW-1:0] p_li_q, p_vi_q, p_vr_q, p_lr_q;

  logic acc, in_grid, out_free;
  logic [AW-1:0] in_idx, pt_idx, nb_idx;
  logic [RW-1:0] rp, rm, nb_r;
  logic [CW-1:0] cp, cm, nb_c;

  logic re_rd_en, fw_en, dw_en;
  logic [AW:0] f_raddr, f_waddr;
  logic [DW-1:0] f_wdata_re, f_wdata_im, re_rdata, im_rdata;
  logic [cfs_pkg::DensW-1:0] d_rdata;
  logic signed [DW-1:0] new_re, new_im;

  assign acc      = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign in_grid  = (32'(row_i) < GRID_ROWS) && (32'(col_i) < GRID_COLS);
  assign in_idx   = AW'(32'(row_i) * GRID_COLS + 32'(col_i));
  assign pt_idx   = AW'(32'(r_q) * GRID_COLS + 32'(c_q));

  assign rp = (r_q == RW'(GRID_ROWS - 1)) ? '0 : r_q + RW'(1);
  assign rm = (r_q == '0) ? RW'(GRID_ROWS - 1) : r_q - RW'(1);
  assign cp = (c_q == CW'(GRID_COLS - 1)) ? '0 : c_q + CW'(1);
  assign cm = (c_q == '0) ? CW'(GRID_COLS - 1) : c_q - CW'(1);

  always_comb begin
    nb_r = r_q;
    nb_c = c_q;
    case (ph_q)
      4'd1:    nb_r = rp;
      4'd2:    nb_r = rm;
      4'd3:    nb_c = cp;
      4'd4:    nb_c = cm;
      default: begin
        nb_r = r_q;
        nb_c = c_q;
      end
    endcase
  end
  assign nb_idx = AW'(32'(nb_r) * GRID_COLS + 32'(nb_c));

  // ram port control
  always_comb begin
    re_rd_en   = 1'b0;
    f_raddr    = {bank_q, nb_idx};
    fw_en      = 1'b0;
    dw_en      = 1'b0;
    f_waddr    = {bank_q, in_idx};
    f_wdata_re = in_re_i;
    f_wdata_im = in_im_i;
    if (state_q == ST_IDLE) begin
      f_raddr = {bank_q, in_idx};
      if (acc && cmd_i == cfs_pkg::CMD_READ && in_grid) begin
        re_rd_en = 1'b1;
      end
      if (acc && cmd_i == cfs_pkg::CMD_WRITE && in_grid) begin
        fw_en = 1'b1;
        dw_en = 1'b1;
      end
    end else if (state_q == ST_RUN) begin
      re_rd_en = (ph_q <= 4'd4);
      if (ph_q == PH_LAST) begin
        fw_en      = 1'b1;
        f_waddr    = {!bank_q, pt_idx};
        f_wdata_re = new_re;
        f_wdata_im = new_im;
      end
    end
  end

  cfs_ram #(.Width(DW), .Depth(FieldDepth)) u_re_ram (
    .clk_i   (clk_i),
    .we_i    (fw_en),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata_re),
    .re_i    (re_rd_en),
    .raddr_i (f_raddr),
    .rdata_o (re_rdata)
  );

  cfs_ram #(.Width(DW), .Depth(FieldDepth)) u_im_ram (
    .clk_i   (clk_i),
    .we_i    (fw_en),
    .waddr_i (f_waddr),
    .wdata_i (f_wdata_im),
    .re_i    (re_rd_en),
    .raddr_i (f_raddr),
    .rdata_o (im_rdata)
  );

  cfs_ram #(.Width(cfs_pkg::DensW), .Depth(1 << AW)) u_dens_ram (
    .clk_i   (clk_i),
    .we_i    (dw_en),
    .waddr_i (in_idx),
    .wdata_i (density_i),
    .re_i    (state_q == ST_RUN && ph_q == 4'd0),
    .raddr_i (pt_idx),
    .rdata_o (d_rdata)
  );

  // final stage: round half up, add, saturate
  logic signed [TW-1:0] t_re, t_im;
  logic signed [NW-1:0] n_re, n_im;
  always_comb begin
    t_re = TW'(p_li_q) - TW'(p_vi_q) + TW'(32768);
    t_im = TW'(p_vr_q) - TW'(p_lr_q) + TW'(32768);
    n_re = NW'(c_re_q) + NW'(t_re >>> 16);
    n_im = NW'(c_im_q) + NW'(t_im >>> 16);
    if (n_re > NW'(cfs_pkg::VAL_MAX)) new_re = cfs_pkg::VAL_MAX;
    else if (n_re < NW'(cfs_pkg::VAL_MIN)) new_re = cfs_pkg::VAL_MIN;
    else new_re = DW'(n_re);
    if (n_im > NW'(cfs_pkg::VAL_MAX)) new_im = cfs_pkg::VAL_MAX;
    else if (n_im < NW'(cfs_pkg::VAL_MIN)) new_im = cfs_pkg::VAL_MIN;
    else new_im = DW'(n_im);
  end

  // datapath registers, no reset
  always_ff @(posedge clk_i) begin
    if (state_q == ST_RUN) begin
      case (ph_q)
        4'd1: begin
          c_re_q <= re_rdata;
          c_im_q <= im_rdata;
          dens_q <= d_rdata;
        end
        4'd2: begin
          sum_re_q <= SumW'($signed(re_rdata));
          sum_im_q <= SumW'($signed(im_rdata));
          vprod_q  <= pot_gain_q * dens_q;
        end
        4'd3, 4'd4, 4'd5: begin
          sum_re_q <= sum_re_q + SumW'($signed(re_rdata));
          sum_im_q <= sum_im_q + SumW'($signed(im_rdata));
        end
        4'd6: begin
          lap_re_q <= LapW'(sum_re_q) - (LapW'(c_re_q) <<< 2);
          lap_im_q <= LapW'(sum_im_q) - (LapW'(c_im_q) <<< 2);
          v_q      <= cfs_pkg::GainW'((vprod_q + 40'd32768) >> 16);
        end
        4'd7: begin
          p_li_q <= PW'($signed({1'b0, lap_gain_q}) * lap_im_q);
          p_lr_q <= PW'($signed({1'b0, lap_gain_q}) * lap_re_q);
          p_vi_q <= PW'($signed({1'b0, v_q}) * c_im_q);
          p_vr_q <= PW'($signed({1'b0, v_q}) * c_re_q);
        end
        default: begin
        end
      endcase
    end
  end

  // sequencer
  always_comb begin
    state_d    = state_q;
    ph_d       = ph_q;
    r_d        = r_q;
    c_d        = c_q;
    bank_d     = bank_q;
    steps_d    = steps_q;
    res_kind_d = res_kind_q;
    res_zero_d = res_zero_q;
    case (state_q)
      ST_IDLE: begin
        if (acc) begin
          res_zero_d = 1'b1;
          case (cmd_i)
            cfs_pkg::CMD_WRITE: begin
              res_kind_d = cfs_pkg::KIND_WRITE_ACK;
              state_d    = ST_DONE;
            end
            cfs_pkg::CMD_RUN: begin
              res_kind_d = cfs_pkg::KIND_RUN_DONE;
              steps_d    = step_count_q;
              ph_d       = '0;
              r_d        = '0;
              c_d        = '0;
              state_d    = (step_count_q == '0) ? ST_DONE : ST_RUN;
            end
            cfs_pkg::CMD_READ: begin
              res_kind_d = cfs_pkg::KIND_READ_DATA;
              res_zero_d = !in_grid;
              state_d    = ST_DONE;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_RUN: begin
        if (ph_q == PH_LAST) begin
          ph_d = '0;
          if (c_q == CW'(GRID_COLS - 1)) begin
            c_d = '0;
            if (r_q == RW'(GRID_ROWS - 1)) begin
              r_d     = '0;
              bank_d  = !bank_q;
              steps_d = steps_q - 1'b1;
              if (steps_q == cfs_pkg::StepW'(1)) state_d = ST_DONE;
            end else begin
              r_d = r_q + RW'(1);
            end
          end else begin
            c_d = c_q + CW'(1);
          end
        end else begin
          ph_d = ph_q + 4'd1;
        end
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ph_q         <= '0;
      r_q          <= '0;
      c_q          <= '0;
      bank_q       <= 1'b0;
      steps_q      <= '0;
      res_kind_q   <= cfs_pkg::KIND_WRITE_ACK;
      res_zero_q   <= 1'b1;
      lap_gain_q   <= '0;
      pot_gain_q   <= '0;
      step_count_q <= cfs_pkg::StepW'(1);
      out_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ph_q       <= ph_d;
      r_q        <= r_d;
      c_q        <= c_d;
      bank_q     <= bank_d;
      steps_q    <= steps_d;
      res_kind_q <= res_kind_d;
      res_zero_q <= res_zero_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfs_pkg::REG_LAP_GAIN:   lap_gain_q   <= cfg_data_i;
          cfs_pkg::REG_POT_GAIN:   pot_gain_q   <= cfg_data_i;
          cfs_pkg::REG_STEP_COUNT: step_count_q <= cfg_data_i[cfs_pkg::StepW-1:0];
          default: begin
          end
        endcase
      end
      if (state_q == ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_DONE && out_free) begin
      out_kind_q <= res_kind_q;
      out_re_q   <= res_zero_q ? '0 : re_rdata;
      out_im_q   <= res_zero_q ? '0 : im_rdata;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_re_o    = out_re_q;
  assign out_im_o    = out_im_q;
  assign kind_o      = out_kind_q;

endmodule
`default_nettype wire

[rtl/cfs_checker.sv]
`default_nettype none
module cfs_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             in_valid_i,
  input wire logic                             in_stall_o,
  input wire logic [cfs_pkg::CmdW-1:0]         cmd_i,
  input wire logic                             out_valid_o,
  input wire logic                             out_stall_i,
  input wire logic signed [cfs_pkg::DataW-1:0] out_re_o,
  input wire logic signed [cfs_pkg::DataW-1:0] out_im_o,
  input wire logic [1:0]                       kind_o
);

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(out_re_o))
    else $error("stalled result changed");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (kind_o == cfs_pkg::KIND_WRITE_ACK || kind_o == cfs_pkg::KIND_RUN_DONE
                     || kind_o == cfs_pkg::KIND_READ_DATA))
    else $error("illegal result kind");

  // only read data carries a field value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != cfs_pkg::KIND_READ_DATA |-> out_re_o == '0 && out_im_o == '0)
    else $error("non-read result carries data");

  // any real command that is taken leaves the block busy in the cycle after
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (cmd_i == cfs_pkg::CMD_WRITE || cmd_i == cfs_pkg::CMD_RUN
                                  || cmd_i == cfs_pkg::CMD_READ) |=> in_stall_o)
    else $error("command taken without going busy");

endmodule

bind complex_field_stencil_euler_step_core cfs_checker u_cfs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .cmd_i       (cmd_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_re_o    (out_re_o),
  .out_im_o    (out_im_o),
  .kind_o      (kind_o)
);
`default_nettype wire

[verif/cfs_checker.sv]
`timescale 1ns / 100ps
module cfs_tb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [cfs_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [cfs_pkg::GainW-1:0]        cfg_data_i,
  input  logic                             in_valid_i,
  input  logic                             in_stall_i,
  input  logic [cfs_pkg::CmdW-1:0]         cmd_i,
  input  logic [cfs_pkg::CoordW-1:0]       row_i,
  input  logic [cfs_pkg::CoordW-1:0]       col_i,
  input  logic signed [cfs_pkg::DataW-1:0] in_re_i,
  input  logic signed [cfs_pkg::DataW-1:0] in_im_i,
  input  logic [cfs_pkg::DensW-1:0]        density_i,
  input  logic                             out_valid_i,
  input  logic                             out_stall_i,
  input  logic signed [cfs_pkg::DataW-1:0] out_re_i,
  input  logic signed [cfs_pkg::DataW-1:0] out_im_i,
  input  logic [1:0]                       kind_i,
  output int                               pending_o,
  output int                               fails_o
);
  localparam int unsigned GridRows = cfs_pkg::GridRows;
  localparam int unsigned GridCols = cfs_pkg::GridCols;
  localparam int unsigned DataW    = cfs_pkg::DataW;
  localparam int unsigned DensW    = cfs_pkg::DensW;
  localparam int unsigned GainW    = cfs_pkg::GainW;
  localparam int unsigned StepW    = cfs_pkg::StepW;
  localparam int Points = GridRows * GridCols;

  typedef struct packed {
    logic signed [DataW-1:0] re;
    logic signed [DataW-1:0] im;
    logic [1:0]              kind;
  } field_result_t;

  logic signed [DataW-1:0] field_re[Points];
  logic signed [DataW-1:0] field_im[Points];
  logic [DensW-1:0]        field_dens[Points];
  logic signed [DataW-1:0] stepped_re[Points];
  logic signed [DataW-1:0] stepped_im[Points];
  logic [GainW-1:0]        lap_gain;
  logic [GainW-1:0]        pot_gain;
  logic [StepW-1:0]        step_count;
  field_result_t           result_q[$];
  int                      mismatches;

  function automatic logic signed [DataW-1:0] clamp24(longint v);
    if (v > longint'(cfs_pkg::VAL_MAX)) return cfs_pkg::VAL_MAX;
    if (v < longint'(cfs_pkg::VAL_MIN)) return cfs_pkg::VAL_MIN;
    return v[DataW-1:0];
  endfunction

  // periodic five-point stencil on the old values
  function automatic longint laplacian(bit imag, int r, int c);
    int rp, rm, cp, cm;
    longint s;
    rp = (r + 1) % GridRows;
    rm = (r + GridRows - 1) % GridRows;
    cp = (c + 1) % GridCols;
    cm = (c + GridCols - 1) % GridCols;
    if (imag)
      s = longint'(field_im[rp*GridCols+c]) + field_im[rm*GridCols+c]
        + field_im[r*GridCols+cp] + field_im[r*GridCols+cm]
        - 4 * longint'(field_im[r*GridCols+c]);
    else
      s = longint'(field_re[rp*GridCols+c]) + field_re[rm*GridCols+c]
        + field_re[r*GridCols+cp] + field_re[r*GridCols+cm]
        - 4 * longint'(field_re[r*GridCols+c]);
    return s;
  endfunction

  task automatic euler_step();
    int i;
    longint pot, re, im, tr, ti;
    for (int r = 0; r < GridRows; r++) begin
      for (int c = 0; c < GridCols; c++) begin
        i = r * GridCols + c;
        pot = (longint'(pot_gain) * longint'(field_dens[i]) + 32768) >>> 16;
        re = field_re[i];
        im = field_im[i];
        tr = longint'(lap_gain) * laplacian(1'b1, r, c) - pot * im;
        ti = pot * re - longint'(lap_gain) * laplacian(1'b0, r, c);
        stepped_re[i] = clamp24(re + ((tr + 32768) >>> 16));
        stepped_im[i] = clamp24(im + ((ti + 32768) >>> 16));
      end
    end
    field_re = stepped_re;
    field_im = stepped_im;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    field_result_t want, got;
    int idx;
    if (!rst_ni) begin
      lap_gain   = '0;
      pot_gain   = '0;
      step_count = 16'd1;
      result_q.delete();
      mismatches = 0;
      pending_o  <= 0;
      fails_o    <= 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          cfs_pkg::REG_LAP_GAIN:   lap_gain = cfg_data_i;
          cfs_pkg::REG_POT_GAIN:   pot_gain = cfg_data_i;
          cfs_pkg::REG_STEP_COUNT: step_count = cfg_data_i[StepW-1:0];
          default: ;
        endcase
      end
      // results go first: a result leaving now belongs to an earlier transaction
      if (out_valid_i && !out_stall_i) begin
        got = '{re: out_re_i, im: out_im_i, kind: kind_i};
        if (result_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: kind %0d re %0d im %0d", kind_i, out_re_i, out_im_i);
        end else begin
          want = result_q.pop_front();
          if (got != want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result mismatch: expected kind %0d re %0d im %0d, %s %0d re %0d im %0d",
                       want.kind, want.re, want.im, "got kind", got.kind, got.re, got.im);
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        idx = row_i * GridCols + col_i;
        case (cmd_i)
          cfs_pkg::CMD_WRITE: begin
            field_re[idx]   = in_re_i;
            field_im[idx]   = in_im_i;
            field_dens[idx] = density_i;
            result_q.push_back('{re: '0, im: '0, kind: cfs_pkg::KIND_WRITE_ACK});
          end
          cfs_pkg::CMD_RUN: begin
            for (int s = 0; s < step_count; s++) euler_step();
            result_q.push_back('{re: '0, im: '0, kind: cfs_pkg::KIND_RUN_DONE});
          end
          cfs_pkg::CMD_READ: result_q.push_back('{re: field_re[idx], im: field_im[idx],
                                                  kind: cfs_pkg::KIND_READ_DATA});
          default: ;
        endcase
      end
      pending_o <= result_q.size();
      fails_o   <= mismatches;
    end
  end
endmodule

[verif/complex_field_stencil_euler_step_core_tb.sv]
`timescale 1ns / 100ps
module complex_field_stencil_euler_step_core_tb;

  localparam int unsigned GridRows = cfs_pkg::GridRows;
  localparam int unsigned GridCols = cfs_pkg::GridCols;
  localparam int unsigned DataW    = cfs_pkg::DataW;
  localparam int unsigned DensW    = cfs_pkg::DensW;
  localparam int unsigned GainW    = cfs_pkg::GainW;
  localparam int unsigned StepW    = cfs_pkg::StepW;
  localparam int unsigned CmdW     = cfs_pkg::CmdW;
  localparam int unsigned CoordW   = cfs_pkg::CoordW;
  localparam int unsigned CfgIdxW  = cfs_pkg::CfgIdxW;
  // the one command code that does nothing
  localparam logic [CmdW-1:0] CmdIgnored = 2'd3;

  localparam int IdleLimit = 400000;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    cfg_we = 1'b0;
  logic [CfgIdxW-1:0]      cfg_idx = '0;
  logic [GainW-1:0]        cfg_data = '0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic [CmdW-1:0]         cmd = cfs_pkg::CMD_WRITE;
  logic [CoordW-1:0]       row = '0;
  logic [CoordW-1:0]       col = '0;
  logic signed [DataW-1:0] in_re = '0;
  logic signed [DataW-1:0] in_im = '0;
  logic [DensW-1:0]        density = '0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic signed [DataW-1:0] out_re;
  logic signed [DataW-1:0] out_im;
  logic [1:0]              kind;
  int                      pending;
  int                      fails;
  int                      tx_idle = 0;
  int                      rx_idle = 0;
  int                      hold_cycles = 0;
  int                      quiet_cycles = 0;

  always #1 clk_i = ~clk_i;

  complex_field_stencil_euler_step_core dut (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .cmd_i(cmd), .row_i(row), .col_i(col),
    .in_re_i(in_re), .in_im_i(in_im), .density_i(density),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .out_re_o(out_re), .out_im_o(out_im), .kind_o(kind)
  );

  cfs_tb_checker u_checker (
    .clk_i, .rst_ni,
    .cfg_we_i(cfg_we), .cfg_idx_i(cfg_idx), .cfg_data_i(cfg_data),
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .cmd_i(cmd), .row_i(row), .col_i(col),
    .in_re_i(in_re), .in_im_i(in_im), .density_i(density),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .out_re_i(out_re), .out_im_i(out_im), .kind_i(kind),
    .pending_o(pending), .fails_o(fails)
  );

  // receiver back-pressure, with an occasional long hold-off
  always @(negedge clk_i) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send(logic [CmdW-1:0] c, logic [CoordW-1:0] r, logic [CoordW-1:0] k,
                      logic signed [DataW-1:0] re, logic signed [DataW-1:0] im,
                      logic [DensW-1:0] d);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_valid <= 1'b1;
    cmd      <= c;
    row      <= r;
    col      <= k;
    in_re    <= re;
    in_im    <= im;
    density  <= d;
    do @(posedge clk_i); while (in_stall);
  endtask

  task automatic drain();
    @(negedge clk_i);
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_reg(logic [CfgIdxW-1:0] idx, logic [GainW-1:0] value);
    @(negedge clk_i);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= value;
    @(negedge clk_i);
    cfg_we   <= 1'b0;
  endtask

  task automatic set_gains(logic [GainW-1:0] lap, logic [GainW-1:0] pot,
                           logic [StepW-1:0] steps);
    set_reg(cfs_pkg::REG_LAP_GAIN, lap);
    set_reg(cfs_pkg::REG_POT_GAIN, pot);
    set_reg(cfs_pkg::REG_STEP_COUNT, GainW'(steps));
  endtask

  task automatic random_point_write();
    send(cfs_pkg::CMD_WRITE, CoordW'($urandom_range(63)), CoordW'($urandom_range(63)),
         DataW'($urandom), DataW'($urandom), DensW'($urandom));
  endtask

  task automatic random_phase(int items);
    int pick;
    int runs;
    runs = 0;
    for (int n = 0; n < items; n++) begin
      pick = $urandom_range(99);
      if (pick < 4 && runs < 3) begin
        send(cfs_pkg::CMD_RUN, CoordW'($urandom), CoordW'($urandom), '0, '0, '0);
        runs++;
      end else if (pick < 8) begin
        // the unused command code has no effect
        send(CmdIgnored, CoordW'($urandom_range(63)), CoordW'($urandom_range(63)),
             DataW'($urandom), DataW'($urandom), DensW'($urandom));
      end else if (pick < 55) begin
        random_point_write();
      end else begin
        send(cfs_pkg::CMD_READ, CoordW'($urandom_range(63)), CoordW'($urandom_range(63)),
             DataW'($urandom), DataW'($urandom), DensW'($urandom));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // the whole grid is loaded before anything reads or runs over it
    set_gains(24'h000400, 24'h000200, 16'd1);
    for (int r = 0; r < GridRows; r++)
      for (int c = 0; c < GridCols; c++)
        send(cfs_pkg::CMD_WRITE, CoordW'(r), CoordW'(c), DataW'($urandom), DataW'($urandom),
             DensW'($urandom));

    send(cfs_pkg::CMD_WRITE, 6'd0, 6'd0, cfs_pkg::VAL_MAX, cfs_pkg::VAL_MIN, 16'hFFFF);
    send(cfs_pkg::CMD_WRITE, 6'd63, 6'd63, cfs_pkg::VAL_MIN, cfs_pkg::VAL_MAX, 16'h0000);
    send(cfs_pkg::CMD_WRITE, 6'd0, 6'd63, '0, '0, 16'h8000);
    send(cfs_pkg::CMD_WRITE, 6'd63, 6'd0, -24'sd1, 24'sd1, 16'h0001);
    send(cfs_pkg::CMD_READ, 6'd0, 6'd0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd63, 6'd63, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd0, 6'd63, '0, '0, '0);
    send(CmdIgnored, 6'd63, 6'd63, cfs_pkg::VAL_MAX, cfs_pkg::VAL_MAX, 16'hFFFF);
    send(cfs_pkg::CMD_READ, 6'd63, 6'd63, '0, '0, '0);
    send(cfs_pkg::CMD_RUN, '0, '0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd0, 6'd0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd63, 6'd0, '0, '0, '0);
    drain();
    set_reg(cfs_pkg::REG_STEP_COUNT, GainW'(0));
    send(cfs_pkg::CMD_RUN, '0, '0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd0, 6'd0, '0, '0, '0);
    drain();
    set_gains(24'hFFFFFF, 24'hFFFFFF, 16'd1);
    send(cfs_pkg::CMD_RUN, '0, '0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd0, 6'd0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd31, 6'd17, '0, '0, '0);
    drain();
    set_reg(cfs_pkg::REG_STEP_COUNT, GainW'(16'hFFFF));
    set_gains(24'h000000, 24'h000000, 16'd2);
    send(cfs_pkg::CMD_RUN, '0, '0, '0, '0, '0);
    send(cfs_pkg::CMD_READ, 6'd5, 6'd9, '0, '0, '0);
    drain();

    tx_idle = 30;
    rx_idle = 80;
    set_gains(GainW'($urandom_range(24'h004000)), GainW'($urandom_range(24'h004000)), 16'd1);
    random_phase(20);
    // long hold-off while items keep coming, so the input backs up
    hold_cycles = 300;
    random_phase(27);
    drain();

    tx_idle = 80;
    rx_idle = 30;
    set_gains(GainW'($urandom), GainW'($urandom), StepW'($urandom_range(1, 2)));
    random_phase(47);
    drain();

    tx_idle = 0;
    rx_idle = 0;
    set_gains(GainW'($urandom_range(24'h001000)), GainW'($urandom_range(24'h010000)), 16'd1);
    random_phase(47);
    drain();

    repeat (20) @(posedge clk_i);
    if (fails == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
